### hw/rtl/bsec_pkg.sv
// Shared types, constants and helper functions of the button and selector event classifier.
package bsec_pkg;

	localparam int TIME_W    = 16;
	localparam int ELAPSED_W = 10;
	localparam int NUM_SEL   = 3;
	localparam int CFG_IDX_W = 3;

	typedef logic [TIME_W-1:0] ms_t;

	localparam logic [CFG_IDX_W-1:0] REG_CLICK_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_PULSE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 3'd3;

	localparam ms_t CLICK_LIMIT_RST   = 16'd1000;
	localparam ms_t HOLD_PULSE_RST    = 16'd500;
	localparam ms_t DEBOUNCE_RST      = 16'd100;
	localparam ms_t REPORT_PERIOD_RST = 16'd1000;
	localparam ms_t TIME_MAX          = 16'hFFFF;

	localparam int SEL_LEFT   = 0;
	localparam int SEL_CENTER = 1;
	localparam int SEL_RIGHT  = 2;

	typedef struct packed {
		ms_t click_limit;
		ms_t hold_pulse;
		ms_t debounce;
		ms_t report_period;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// Pin group of each selector inside selector_levels.
	function automatic int unsigned sel_group(input int unsigned s);
		int unsigned g;
		case (s)
			SEL_LEFT:   g = 1;
			SEL_CENTER: g = 2;
			default:    g = 0;
		endcase
		return g;
	endfunction

	function automatic ms_t sat_add(input ms_t a, input logic [ELAPSED_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

### hw/rtl/bsec_if.sv
// Sample and result channel interfaces of the event classifier.
interface bsec_sample_if import bsec_pkg::*; #(
	parameter int NB = 9,
	parameter int SP = 8
) ();
	logic                    valid;
	logic                    ready;
	logic [NB-1:0]           button_levels;
	logic [NUM_SEL*SP-1:0]   selector_levels;
	logic [ELAPSED_W-1:0]    elapsed_ms;

	modport source (output valid, button_levels, selector_levels, elapsed_ms, input ready);
	modport sink (input valid, button_levels, selector_levels, elapsed_ms, output ready);
endinterface

interface bsec_result_if import bsec_pkg::*; #(
	parameter int NB = 9,
	parameter int SP = 8,
	localparam int PW = $clog2(SP)
) ();
	logic               valid;
	logic               ready;
	logic [NB-1:0]      pressed_mask;
	logic [NB-1:0]      released_mask;
	logic [NB-1:0]      click_mask;
	logic [NB-1:0]      long_click_mask;
	logic [NB-1:0]      long_held_mask;
	logic [NUM_SEL-1:0] selector_changed;
	logic [PW-1:0]      left_position;
	logic [PW-1:0]      center_position;
	logic [PW-1:0]      right_position;
	logic               report_valid;

	modport source (output valid, pressed_mask, released_mask, click_mask, long_click_mask,
		long_held_mask, selector_changed, left_position, center_position, right_position,
		report_valid, input ready);
	modport sink (input valid, pressed_mask, released_mask, click_mask, long_click_mask,
		long_held_mask, selector_changed, left_position, center_position, right_position,
		report_valid, output ready);
endinterface

### hw/rtl/bsec_div.sv
// Bit-serial remainder unit that advances the long-held pulse times of all buttons.
module bsec_div import bsec_pkg::*; #(
	parameter int NB = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NB-1:0]                lanes,
	input  logic [NB-1:0][ELAPSED_W-1:0] diff,
	input  logic [NB-1:0][TIME_W-1:0]    base,
	input  ms_t                          pulse,
	output div_sts_t                     sts,
	output logic [NB-1:0]                done_lanes,
	output logic [NB-1:0][TIME_W-1:0]    next_time
);
	localparam int CNT_W = $clog2(ELAPSED_W + 1);

	logic [CNT_W-1:0]               cnt_q;
	logic                           done_q;
	logic [NB-1:0]                  lanes_q;
	logic [NB-1:0][ELAPSED_W-1:0]   num_q;
	logic [NB-1:0][ELAPSED_W-1:0]   rem_q;
	logic [NB-1:0][TIME_W-1:0]      base_q;
	ms_t                            pulse_q;
	logic [NB-1:0][TIME_W:0]        trial;
	logic [NB-1:0][TIME_W:0]        sum;

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			trial[i] = (TIME_W + 1)'({rem_q[i], num_q[i][ELAPSED_W-1]});
			sum[i] = {1'b0, base_q[i]} + {1'b0, pulse_q}
				- {{(TIME_W + 1 - ELAPSED_W){1'b0}}, rem_q[i]};
			next_time[i] = sum[i][TIME_W] ? '0 : sum[i][TIME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(ELAPSED_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lanes_q <= lanes;
			num_q <= diff;
			rem_q <= '0;
			base_q <= base;
			pulse_q <= pulse;
		end else if (cnt_q != '0) begin
			for (int i = 0; i < NB; i++) begin
				num_q[i] <= {num_q[i][ELAPSED_W-2:0], 1'b0};
				if (trial[i] >= {1'b0, pulse_q}) begin
					rem_q[i] <= ELAPSED_W'(trial[i] - {1'b0, pulse_q});
				end else begin
					rem_q[i] <= ELAPSED_W'(trial[i]);
				end
			end
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign done_lanes = lanes_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (cnt_q == '0 && !done_q))
		else $error("remainder unit started while still working");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("remainder done held longer than one cycle");
`endif
endmodule

### hw/rtl/bsec_front.sv
// Front stage: takes samples, classifies button events and latches falling selector pins.
module bsec_front import bsec_pkg::*; #(
	parameter int NB = 9,
	parameter int SP = 8,
	localparam int PW = $clog2(SP)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	bsec_sample_if.sink                    sample,
	input  logic                           queue_full,
	input  div_sts_t                       div_sts,
	input  logic [NB-1:0]                  div_lanes,
	input  logic [NB-1:0][TIME_W-1:0]      div_next,
	output logic                           div_start,
	output logic [NB-1:0]                  div_mask,
	output logic [NB-1:0][ELAPSED_W-1:0]   div_diff,
	output logic [NB-1:0][TIME_W-1:0]      div_base,
	output ms_t                            div_pulse,
	output logic                           push,
	output logic [NB-1:0]                  pressed,
	output logic [NB-1:0]                  released,
	output logic [NB-1:0]                  click,
	output logic [NB-1:0]                  long_click,
	output logic [NB-1:0]                  long_held,
	output logic [NUM_SEL-1:0][PW-1:0]     raw_pos,
	output logic [ELAPSED_W-1:0]           elapsed
);
	logic [NB-1:0]                  prev_q;
	logic [NB-1:0]                  down_q;
	logic [NB-1:0][TIME_W-1:0]      hold_q;
	logic [NB-1:0][TIME_W-1:0]      next_q;
	logic [NUM_SEL*SP-1:0]          sel_prev_q;
	logic [NUM_SEL-1:0][PW-1:0]     raw_q;

	logic                           accept;
	ms_t                            pulse;
	logic [NB-1:0]                  chg;
	logic [NB-1:0][TIME_W-1:0]      hold_add;
	logic [NUM_SEL-1:0][SP-1:0]     fall;

	assign sample.ready = !queue_full && !div_sts.busy && !div_sts.done;
	assign accept = sample.valid && sample.ready;

	always_comb begin
		pulse = (cfg.hold_pulse == '0) ? ms_t'(1) : cfg.hold_pulse;
		chg = sample.button_levels ^ prev_q;
		for (int i = 0; i < NB; i++) begin
			hold_add[i] = down_q[i] ? sat_add(hold_q[i], sample.elapsed_ms) : hold_q[i];
			pressed[i] = chg[i] & ~down_q[i];
			released[i] = chg[i] & down_q[i];
			click[i] = released[i] & (hold_add[i] < cfg.click_limit);
			long_click[i] = released[i] & (hold_add[i] >= cfg.click_limit);
			long_held[i] = ~chg[i] & down_q[i] & (next_q[i] != '0)
				& (hold_add[i] >= next_q[i]);
			div_diff[i] = ELAPSED_W'(hold_add[i] - next_q[i]);
		end
	end

	// The highest falling pin of a selector wins.
	always_comb begin
		for (int s = 0; s < NUM_SEL; s++) begin
			fall[s] = sel_prev_q[sel_group(s)*SP +: SP]
				& ~sample.selector_levels[sel_group(s)*SP +: SP];
			raw_pos[s] = raw_q[s];
			for (int p = 0; p < SP; p++) begin
				if (fall[s][p]) begin
					raw_pos[s] = PW'(p);
				end
			end
		end
	end

	assign push = accept;
	assign elapsed = sample.elapsed_ms;
	assign div_start = accept && (|long_held);
	assign div_mask = long_held;
	assign div_base = hold_add;
	assign div_pulse = pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '1;
			down_q <= '0;
			hold_q <= '0;
			next_q <= '0;
			sel_prev_q <= '1;
			raw_q <= '0;
		end else begin
			if (accept) begin
				prev_q <= sample.button_levels;
				down_q <= down_q ^ chg;
				sel_prev_q <= sample.selector_levels;
				raw_q <= raw_pos;
				for (int i = 0; i < NB; i++) begin
					if (pressed[i]) begin
						hold_q[i] <= '0;
						next_q[i] <= pulse;
					end else begin
						hold_q[i] <= hold_add[i];
					end
				end
			end
			if (div_sts.done) begin
				for (int i = 0; i < NB; i++) begin
					if (div_lanes[i]) begin
						next_q[i] <= div_next[i];
					end
				end
			end
		end
	end
endmodule

### hw/rtl/bsec_fifo.sv
// Short queue of classified sample records between the front and back stages.
module bsec_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW + 1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW + 1)'(DEPTH))
		else $error("queue count beyond depth");
`endif
endmodule

### hw/rtl/bsec_back.sv
// Back stage: selector debounce compare, periodic report timer and the result register.
module bsec_back import bsec_pkg::*; #(
	parameter int NB = 9,
	parameter int SP = 8,
	localparam int PW = $clog2(SP)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       avail,
	output logic                       pop,
	input  logic [NB-1:0]              pressed,
	input  logic [NB-1:0]              released,
	input  logic [NB-1:0]              click,
	input  logic [NB-1:0]              long_click,
	input  logic [NB-1:0]              long_held,
	input  logic [NUM_SEL-1:0][PW-1:0] raw_pos,
	input  logic [ELAPSED_W-1:0]       elapsed,
	bsec_result_if.source              result
);
	ms_t                        dt_q;
	ms_t                        rt_q;
	logic [NUM_SEL-1:0][PW-1:0] cmp_q;
	logic [NUM_SEL-1:0][PW-1:0] stab_q;
	logic                       out_valid_q;
	logic [NB-1:0]              pressed_q;
	logic [NB-1:0]              released_q;
	logic [NB-1:0]              click_q;
	logic [NB-1:0]              long_click_q;
	logic [NB-1:0]              long_held_q;
	logic [NUM_SEL-1:0]         changed_q;
	logic [NUM_SEL-1:0][PW-1:0] pos_q;
	logic                       report_q;

	ms_t                        dt_add;
	ms_t                        rt_add;
	logic                       deb_fire;
	logic                       rep_fire;
	logic [NUM_SEL-1:0]         changed;
	logic [NUM_SEL-1:0][PW-1:0] stab_n;

	assign pop = avail && (!out_valid_q || result.ready);

	always_comb begin
		dt_add = sat_add(dt_q, elapsed);
		rt_add = sat_add(rt_q, elapsed);
		deb_fire = (dt_add > cfg.debounce);
		rep_fire = (rt_add > cfg.report_period);
		for (int s = 0; s < NUM_SEL; s++) begin
			changed[s] = deb_fire && (raw_pos[s] != cmp_q[s]);
			stab_n[s] = changed[s] ? raw_pos[s] : stab_q[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= '0;
			rt_q <= '0;
			cmp_q <= '0;
			stab_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				dt_q <= deb_fire ? '0 : dt_add;
				rt_q <= rep_fire ? '0 : rt_add;
				if (deb_fire) begin
					cmp_q <= raw_pos;
				end
				stab_q <= stab_n;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pressed_q <= pressed;
			released_q <= released;
			click_q <= click;
			long_click_q <= long_click;
			long_held_q <= long_held;
			changed_q <= changed;
			pos_q <= stab_n;
			report_q <= rep_fire;
		end
	end

	assign result.valid = out_valid_q;
	assign result.pressed_mask = pressed_q;
	assign result.released_mask = released_q;
	assign result.click_mask = click_q;
	assign result.long_click_mask = long_click_q;
	assign result.long_held_mask = long_held_q;
	assign result.selector_changed = changed_q;
	assign result.left_position = pos_q[SEL_LEFT];
	assign result.center_position = pos_q[SEL_CENTER];
	assign result.right_position = pos_q[SEL_RIGHT];
	assign result.report_valid = report_q;
endmodule

### hw/rtl/button_and_selector_event_classifier.sv
// Top level of the button and rotary selector event classifier.
//
// Channel  Direction  Beat
// sample   in         button_levels, selector_levels, elapsed_ms
// result   out        event masks, selector_changed, positions, report_valid
// cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// A sample is taken every cycle while the four-beat queue has room and the remainder unit is idle.
// Its classified record passes through the queue into the result register.
// A sample that raises a long-held pulse holds sample.ready low while the shared
// remainder unit finds the next pulse times one bit per cycle and hands them back.
// The result register and the queue let the result side stall without stopping intake until the queue is full.
// Reset is asynchronous and needs no clearing pass.
module button_and_selector_event_classifier import bsec_pkg::*; #(
	parameter int NUM_BUTTONS = 9,
	parameter int SELECTOR_POSITIONS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	bsec_sample_if.sink          sample,
	bsec_result_if.source        result
);
	localparam int NB = NUM_BUTTONS;
	localparam int SP = SELECTOR_POSITIONS;
	localparam int PW = $clog2(SP);
	localparam int QUEUE_DEPTH = 4;
	localparam int O_RAW = ELAPSED_W;
	localparam int O_HELD = O_RAW + NUM_SEL * PW;
	localparam int O_LCLK = O_HELD + NB;
	localparam int O_CLK = O_LCLK + NB;
	localparam int O_REL = O_CLK + NB;
	localparam int O_PRS = O_REL + NB;
	localparam int REC_W = O_PRS + NB;

	cfg_t                         cfg_q;
	div_sts_t                     div_sts;
	logic                         div_start;
	logic [NB-1:0]                div_mask;
	logic [NB-1:0][ELAPSED_W-1:0] div_diff;
	logic [NB-1:0][TIME_W-1:0]    div_base;
	ms_t                          div_pulse;
	logic [NB-1:0]                div_lanes;
	logic [NB-1:0][TIME_W-1:0]    div_next;

	logic                         push;
	logic                         pop;
	logic                         full;
	logic                         empty;
	logic [NB-1:0]                f_pressed;
	logic [NB-1:0]                f_released;
	logic [NB-1:0]                f_click;
	logic [NB-1:0]                f_long_click;
	logic [NB-1:0]                f_long_held;
	logic [NUM_SEL-1:0][PW-1:0]   f_raw;
	logic [ELAPSED_W-1:0]         f_elapsed;
	logic [REC_W-1:0]             rec_in;
	logic [REC_W-1:0]             rec_out;
	logic [NUM_SEL-1:0][PW-1:0]   b_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_limit <= CLICK_LIMIT_RST;
			cfg_q.hold_pulse <= HOLD_PULSE_RST;
			cfg_q.debounce <= DEBOUNCE_RST;
			cfg_q.report_period <= REPORT_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLICK_LIMIT:   cfg_q.click_limit <= cfg_data;
				REG_HOLD_PULSE:    cfg_q.hold_pulse <= cfg_data;
				REG_DEBOUNCE:      cfg_q.debounce <= cfg_data;
				REG_REPORT_PERIOD: cfg_q.report_period <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	bsec_front #(
		.NB(NB),
		.SP(SP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample     (sample),
		.queue_full (full),
		.div_sts    (div_sts),
		.div_lanes  (div_lanes),
		.div_next   (div_next),
		.div_start  (div_start),
		.div_mask   (div_mask),
		.div_diff   (div_diff),
		.div_base   (div_base),
		.div_pulse  (div_pulse),
		.push       (push),
		.pressed    (f_pressed),
		.released   (f_released),
		.click      (f_click),
		.long_click (f_long_click),
		.long_held  (f_long_held),
		.raw_pos    (f_raw),
		.elapsed    (f_elapsed)
	);

	bsec_div #(
		.NB(NB)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.lanes      (div_mask),
		.diff       (div_diff),
		.base       (div_base),
		.pulse      (div_pulse),
		.sts        (div_sts),
		.done_lanes (div_lanes),
		.next_time  (div_next)
	);

	assign rec_in = {f_pressed, f_released, f_click, f_long_click, f_long_held, f_raw, f_elapsed};

	bsec_fifo #(
		.W(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (rec_in),
		.full   (full),
		.pop    (pop),
		.dout   (rec_out),
		.empty  (empty)
	);

	assign b_raw = rec_out[O_HELD-1:O_RAW];

	bsec_back #(
		.NB(NB),
		.SP(SP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.avail      (!empty),
		.pop        (pop),
		.pressed    (rec_out[O_PRS +: NB]),
		.released   (rec_out[O_REL +: NB]),
		.click      (rec_out[O_CLK +: NB]),
		.long_click (rec_out[O_LCLK +: NB]),
		.long_held  (rec_out[O_HELD +: NB]),
		.raw_pos    (b_raw),
		.elapsed    (rec_out[ELAPSED_W-1:0]),
		.result     (result)
	);
endmodule

### tb/button_and_selector_event_classifier_tb.sv
// Self-checking testbench of the button and rotary selector event classifier.
`timescale 1ns / 100ps

module button_and_selector_event_classifier_tb import bsec_pkg::*; ();

	localparam int NB = 9;
	localparam int SP = 8;
	localparam int PW = $clog2(SP);
	localparam int SEL_W = NUM_SEL * SP;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;
	localparam logic [NB-1:0] BUTTONS_UP = '1;
	localparam logic [SEL_W-1:0] PINS_UP = '1;

	typedef struct packed {
		logic [NB-1:0]      pressed;
		logic [NB-1:0]      released;
		logic [NB-1:0]      click;
		logic [NB-1:0]      long_click;
		logic [NB-1:0]      long_held;
		logic [NUM_SEL-1:0] changed;
		logic [PW-1:0]      left_pos;
		logic [PW-1:0]      center_pos;
		logic [PW-1:0]      right_pos;
		logic               report;
	} classified_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;

	bsec_sample_if #(.NB(NB), .SP(SP)) sample_ch ();
	bsec_result_if #(.NB(NB), .SP(SP)) result_ch ();

	button_and_selector_event_classifier #(
		.NUM_BUTTONS(NB),
		.SELECTOR_POSITIONS(SP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.result(result_ch)
	);

	cfg_t          cfg_now;
	logic [NB-1:0] btn_last_level;
	logic [NB-1:0] btn_held;
	ms_t           hold_ms [NB];
	ms_t           next_pulse_ms [NB];
	logic [SEL_W-1:0] sel_last_level;
	logic [PW-1:0] latched_pos [NUM_SEL];
	logic [PW-1:0] compared_pos [NUM_SEL];
	logic [PW-1:0] stable_pos [NUM_SEL];
	ms_t           debounce_acc;
	ms_t           report_acc;

	classified_t expected_events [$];
	classified_t oldest;

	logic [NB-1:0]    last_lv;
	logic [SEL_W-1:0] last_sl;
	int sender_idle_pct = 7;
	int stall_pct = 78;
	int errors = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count++;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic reset_model();
		cfg_now.click_limit = CLICK_LIMIT_RST;
		cfg_now.hold_pulse = HOLD_PULSE_RST;
		cfg_now.debounce = DEBOUNCE_RST;
		cfg_now.report_period = REPORT_PERIOD_RST;
		btn_last_level = '1;
		btn_held = '0;
		for (int i = 0; i < NB; i++) begin
			hold_ms[i] = '0;
			next_pulse_ms[i] = '0;
		end
		sel_last_level = '1;
		for (int s = 0; s < NUM_SEL; s++) begin
			latched_pos[s] = '0;
			compared_pos[s] = '0;
			stable_pos[s] = '0;
		end
		debounce_acc = '0;
		report_acc = '0;
	endtask

	function automatic ms_t add_capped(input ms_t acc, input logic [ELAPSED_W-1:0] el);
		int unsigned total;
		total = acc + el;
		return (total > TIME_MAX) ? TIME_MAX : ms_t'(total);
	endfunction

	function automatic classified_t classify_sample(input logic [NB-1:0] lv,
			input logic [SEL_W-1:0] sl, input logic [ELAPSED_W-1:0] el);
		classified_t r;
		int unsigned pulse, h, np, k, n;
		int base;
		logic was_down;
		logic [SEL_W-1:0] fall;
		r = '0;
		pulse = (cfg_now.hold_pulse == 0) ? 1 : cfg_now.hold_pulse;
		for (int i = 0; i < NB; i++) begin
			was_down = btn_held[i];
			if (was_down)
				hold_ms[i] = add_capped(hold_ms[i], el);
			if (lv[i] != btn_last_level[i]) begin
				if (!was_down) begin
					btn_held[i] = 1'b1;
					r.pressed[i] = 1'b1;
					hold_ms[i] = '0;
					next_pulse_ms[i] = ms_t'(pulse);
				end else begin
					btn_held[i] = 1'b0;
					r.released[i] = 1'b1;
					if (hold_ms[i] < cfg_now.click_limit)
						r.click[i] = 1'b1;
					else
						r.long_click[i] = 1'b1;
				end
			end else if (was_down && next_pulse_ms[i] != 0 && hold_ms[i] >= next_pulse_ms[i]) begin
				h = hold_ms[i];
				np = next_pulse_ms[i];
				k = (h - np) / pulse + 1;
				n = np + k * pulse;
				r.long_held[i] = 1'b1;
				next_pulse_ms[i] = (n > TIME_MAX) ? '0 : ms_t'(n);
			end
		end
		btn_last_level = lv;

		fall = sel_last_level & ~sl;
		for (int s = 0; s < NUM_SEL; s++) begin
			base = (s == SEL_LEFT) ? SP : (s == SEL_CENTER) ? 2 * SP : 0;
			for (int p = 0; p < SP; p++)
				if (fall[base + p])
					latched_pos[s] = PW'(p);
		end
		sel_last_level = sl;

		debounce_acc = add_capped(debounce_acc, el);
		if (debounce_acc > cfg_now.debounce) begin
			for (int s = 0; s < NUM_SEL; s++) begin
				if (latched_pos[s] != compared_pos[s]) begin
					stable_pos[s] = latched_pos[s];
					r.changed[s] = 1'b1;
				end
				compared_pos[s] = latched_pos[s];
			end
			debounce_acc = '0;
		end

		report_acc = add_capped(report_acc, el);
		if (report_acc > cfg_now.report_period) begin
			r.report = 1'b1;
			report_acc = '0;
		end

		r.left_pos = stable_pos[SEL_LEFT];
		r.center_pos = stable_pos[SEL_CENTER];
		r.right_pos = stable_pos[SEL_RIGHT];
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready)
			expected_events.push_back(classify_sample(sample_ch.button_levels,
				sample_ch.selector_levels, sample_ch.elapsed_ms));
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_events.size() == 0) begin
				$error("result beat arrived with no sample outstanding");
				errors++;
			end else begin
				oldest = expected_events.pop_front();
				results_checked++;
				check_field("pressed_mask", oldest.pressed, result_ch.pressed_mask);
				check_field("released_mask", oldest.released, result_ch.released_mask);
				check_field("click_mask", oldest.click, result_ch.click_mask);
				check_field("long_click_mask", oldest.long_click, result_ch.long_click_mask);
				check_field("long_held_mask", oldest.long_held, result_ch.long_held_mask);
				check_field("selector_changed", oldest.changed, result_ch.selector_changed);
				check_field("left_position", oldest.left_pos, result_ch.left_position);
				check_field("center_position", oldest.center_pos, result_ch.center_position);
				check_field("right_position", oldest.right_pos, result_ch.right_position);
				check_field("report_valid", oldest.report, result_ch.report_valid);
			end
		end
	end

	task automatic send_sample(input logic [NB-1:0] lv, input logic [SEL_W-1:0] sl,
			input logic [ELAPSED_W-1:0] el);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			sample_ch.valid = 1'b0;
		end
		@(negedge clk);
		sample_ch.valid = 1'b1;
		sample_ch.button_levels = lv;
		sample_ch.selector_levels = sl;
		sample_ch.elapsed_ms = el;
		do @(posedge clk); while (!sample_ch.ready);
		last_lv = lv;
		last_sl = sl;
		samples_sent++;
	endtask

	task automatic settle_block();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input ms_t val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_CLICK_LIMIT:   cfg_now.click_limit = val;
			REG_HOLD_PULSE:    cfg_now.hold_pulse = val;
			REG_DEBOUNCE:      cfg_now.debounce = val;
			REG_REPORT_PERIOD: cfg_now.report_period = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_button_press_release();
		send_sample(BUTTONS_UP, PINS_UP, 0);
		send_sample('0, PINS_UP, 1023);
		send_sample('0, PINS_UP, 1023);
		send_sample(9'h155, PINS_UP, 0);
		send_sample(BUTTONS_UP, PINS_UP, 1);
		send_sample(9'h1FE, PINS_UP, 7);
		send_sample(BUTTONS_UP, PINS_UP, 999);
		send_sample(9'h1FE, PINS_UP, 0);
		send_sample(BUTTONS_UP, PINS_UP, 1000);
	endtask

	task automatic test_selector_positions();
		logic [SEL_W-1:0] sl;
		sl = PINS_UP;
		sl[SP + 5] = 1'b0;
		sl[2 * SP + 2] = 1'b0;
		sl[2 * SP + 6] = 1'b0;
		sl[7] = 1'b0;
		send_sample(BUTTONS_UP, PINS_UP, 0);
		send_sample(BUTTONS_UP, sl, 101);
		send_sample(BUTTONS_UP, sl, 1023);
		send_sample(BUTTONS_UP, '0, 0);
		send_sample(BUTTONS_UP, PINS_UP, 101);
		send_sample(BUTTONS_UP, PINS_UP & ~24'h1, 50);
	endtask

	task automatic test_config_extremes();
		settle_block();
		write_reg(REG_CLICK_LIMIT, '0);
		write_reg(REG_HOLD_PULSE, '0);
		write_reg(REG_DEBOUNCE, '0);
		write_reg(REG_REPORT_PERIOD, '0);
		send_sample('0, PINS_UP, 0);
		send_sample('0, '0, 1023);
		send_sample('0, '0, 0);
		send_sample(BUTTONS_UP, PINS_UP, 3);
		settle_block();
		write_reg(REG_SPARE_FIRST, ms_t'($urandom));
		write_reg(REG_SPARE_LAST, TIME_MAX);
		send_sample(9'h0F0, PINS_UP & ~24'h800000, 1);
		settle_block();
		write_reg(REG_CLICK_LIMIT, TIME_MAX);
		write_reg(REG_HOLD_PULSE, TIME_MAX);
		write_reg(REG_DEBOUNCE, TIME_MAX);
		write_reg(REG_REPORT_PERIOD, TIME_MAX);
		send_sample(9'h0F0, PINS_UP, 1023);
		send_sample(BUTTONS_UP, PINS_UP, 1023);
	endtask

	task automatic run_random(input int count, input int el_cap);
		logic [NB-1:0] lv;
		logic [SEL_W-1:0] sl;
		logic [ELAPSED_W-1:0] el;
		logic [SP-1:0] grp;
		int pick;
		for (int n = 0; n < count; n++) begin
			lv = last_lv;
			for (int i = 0; i < NB; i++)
				if ($urandom_range(999) < ((i == NB - 1) ? 8 : 70))
					lv[i] = ~lv[i];
			if ($urandom_range(99) < 4)
				lv = NB'($urandom);
			sl = last_sl;
			for (int s = 0; s < NUM_SEL; s++) begin
				pick = $urandom_range(99);
				if (pick < 12) begin
					grp = '1;
					grp[$urandom_range(SP - 1, 0)] = 1'b0;
					sl[s * SP +: SP] = grp;
				end else if (pick < 15) begin
					sl[s * SP +: SP] = SP'($urandom);
				end
			end
			if ($urandom_range(99) < 4)
				sl = SEL_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 8)
				el = '0;
			else if (pick < 16)
				el = '1;
			else
				el = ELAPSED_W'($urandom_range(el_cap, 0));
			// Let the block run dry once in the middle of every phase.
			if (n == count / 2)
				settle_block();
			send_sample(lv, sl, el);
		end
	endtask

	task automatic test_random_slow_receiver();
		settle_block();
		sender_idle_pct = 7;
		stall_pct = 78;
		write_reg(REG_CLICK_LIMIT, ms_t'($urandom_range(3000, 500)));
		write_reg(REG_HOLD_PULSE, ms_t'($urandom_range(1000, 100)));
		write_reg(REG_DEBOUNCE, ms_t'($urandom_range(300, 50)));
		write_reg(REG_REPORT_PERIOD, ms_t'($urandom_range(3000, 500)));
		run_random(230, 1023);
	endtask

	task automatic test_random_slow_sender();
		settle_block();
		sender_idle_pct = 78;
		stall_pct = 7;
		write_reg(REG_CLICK_LIMIT, ms_t'($urandom_range(40, 1)));
		write_reg(REG_HOLD_PULSE, 16'd1);
		write_reg(REG_DEBOUNCE, ms_t'($urandom_range(40, 1)));
		write_reg(REG_REPORT_PERIOD, ms_t'($urandom_range(40, 1)));
		run_random(230, 40);
	endtask

	task automatic test_random_full_rate();
		settle_block();
		sender_idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_CLICK_LIMIT, TIME_MAX);
		write_reg(REG_HOLD_PULSE, TIME_MAX);
		write_reg(REG_DEBOUNCE, ms_t'($urandom_range(2000, 1)));
		write_reg(REG_REPORT_PERIOD, TIME_MAX);
		run_random(240, 1023);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CLICK_LIMIT;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.button_levels = BUTTONS_UP;
		sample_ch.selector_levels = PINS_UP;
		sample_ch.elapsed_ms = '0;
		last_lv = BUTTONS_UP;
		last_sl = PINS_UP;
		reset_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_button_press_release();
		test_selector_positions();
		test_config_extremes();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_full_rate();
		settle_block();

		$display("Classified %0d poll samples and checked %0d result beats in %0d cycles,",
			samples_sent, results_checked, cycle_count);
		$display("over default, zero, spare-index, small, mid-range and full-scale settings.");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
